>>> hw/rtl/ssh_pkg.sv
`default_nettype none

package ssh_pkg;

    // result bits of the square root, quotient bits of the divide, rotation steps
    localparam int SQ_BITS      = 34;
    localparam int DIV_BITS     = 33;
    localparam int CORDIC_STEPS = 24;

    localparam logic signed [27:0] PI_Q24     = 28'sd52707179;
    localparam logic signed [28:0] HEAD_LIMIT = 29'sd25736;
    localparam logic [65:0]        HEAD_THRESH_SQ = 66'd4295;
    localparam logic [32:0]        DISP_MAX   = 33'h1_FFFF_FFFF;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_TARGET_X  = 2'd0,
        CFG_TARGET_Y  = 2'd1,
        CFG_TARGET_Z  = 2'd2,
        CFG_MAX_SPEED = 2'd3
    } cfg_idx_t;

    // everything one transaction carries down the chain
    typedef struct packed {
        logic [2:0][31:0]       pos;
        logic [2:0]             neg;
        logic [2:0][32:0]       mag;
        logic [32:0]            disp;
        logic [2:0][33:0]       pp_hh;
        logic [2:0][32:0]       pp_hl;
        logic [2:0][31:0]       pp_ll;
        logic [2:0][65:0]       sqa;
        logic [67:0]            sq;
        logic [35:0]            rem;
        logic [33:0]            root;
        logic signed [59:0]     cx;
        logic signed [59:0]     cy;
        logic signed [27:0]     cz;
        logic                   hval;
        logic                   reached;
        logic [2:0][48:0]       ph;
        logic [2:0][49:0]       pl;
        logic [2:0][33:0]       drem;
        logic [2:0][32:0]       dnum;
        logic [2:0][32:0]       quot;
    } item_t;

    // atan(2^-i) in units of 2^-24 rad
    function automatic logic signed [27:0] atan_q24(input int idx);
        logic signed [27:0] a;
        unique case (idx)
            0:  a = 28'sd13176795;
            1:  a = 28'sd7778716;
            2:  a = 28'sd4110060;
            3:  a = 28'sd2086331;
            4:  a = 28'sd1047214;
            5:  a = 28'sd524117;
            6:  a = 28'sd262123;
            7:  a = 28'sd131069;
            8:  a = 28'sd65536;
            9:  a = 28'sd32768;
            10: a = 28'sd16384;
            11: a = 28'sd8192;
            12: a = 28'sd4096;
            13: a = 28'sd2048;
            14: a = 28'sd1024;
            15: a = 28'sd512;
            16: a = 28'sd256;
            17: a = 28'sd128;
            18: a = 28'sd64;
            19: a = 28'sd32;
            20: a = 28'sd16;
            21: a = 28'sd8;
            22: a = 28'sd4;
            23: a = 28'sd2;
            default: a = 28'sd0;
        endcase
        return a;
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/ssh_root_cell.sv
`default_nettype none

module ssh_root_cell #(
    parameter int Idx = 0
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          load,
    input  wire logic          v_in,
    input  wire ssh_pkg::item_t d_in,
    output logic               v_out,
    output ssh_pkg::item_t     d_out
);
    import ssh_pkg::*;

    logic               v_reg;
    item_t              item_reg;
    item_t              item_next;
    logic [37:0]        rem2;
    logic [37:0]        trial;
    logic signed [59:0] xs;
    logic signed [59:0] ys;

    // one square root bit, plus one rotation step while steps remain
    always_comb
    begin
        item_next = d_in;
        rem2  = {d_in.rem, d_in.sq[67:66]};
        trial = {2'b00, d_in.root, 2'b01};
        if (rem2 >= trial)
        begin
            item_next.rem  = 36'(rem2 - trial);
            item_next.root = {d_in.root[32:0], 1'b1};
        end
        else
        begin
            item_next.rem  = rem2[35:0];
            item_next.root = {d_in.root[32:0], 1'b0};
        end
        item_next.sq = {d_in.sq[65:0], 2'b00};

        xs = d_in.cx >>> Idx;
        ys = d_in.cy >>> Idx;
        if (Idx < CORDIC_STEPS)
        begin
            if (!d_in.cy[59])
            begin
                item_next.cx = d_in.cx + ys;
                item_next.cy = d_in.cy - xs;
                item_next.cz = d_in.cz + atan_q24(Idx);
            end
            else
            begin
                item_next.cx = d_in.cx - ys;
                item_next.cy = d_in.cy + xs;
                item_next.cz = d_in.cz - atan_q24(Idx);
            end
        end
    end

    // stage register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else if (load)
        begin
            v_reg <= v_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= item_next;
        end
    end

    assign v_out = v_reg;
    assign d_out = item_reg;

endmodule

`default_nettype wire

>>> hw/rtl/ssh_div_cell.sv
`default_nettype none

module ssh_div_cell (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          load,
    input  wire logic          v_in,
    input  wire ssh_pkg::item_t d_in,
    output logic               v_out,
    output ssh_pkg::item_t     d_out
);
    import ssh_pkg::*;

    logic        v_reg;
    item_t       item_reg;
    item_t       item_next;
    logic [34:0] r2   [3];
    logic [34:0] lval;

    // one quotient bit for each axis, divisor is the length
    always_comb
    begin
        item_next = d_in;
        lval = {1'b0, d_in.root};
        for (int a = 0; a < 3; a++)
        begin
            r2[a] = {d_in.drem[a], d_in.dnum[a][32]};
            if (r2[a] >= lval)
            begin
                item_next.drem[a] = 34'(r2[a] - lval);
                item_next.quot[a] = {d_in.quot[a][31:0], 1'b1};
            end
            else
            begin
                item_next.drem[a] = r2[a][33:0];
                item_next.quot[a] = {d_in.quot[a][31:0], 1'b0};
            end
            item_next.dnum[a] = {d_in.dnum[a][31:0], 1'b0};
        end
    end

    // stage register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else if (load)
        begin
            v_reg <= v_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= item_next;
        end
    end

    assign v_out = v_reg;
    assign d_out = item_reg;

endmodule

`default_nettype wire

>>> hw/rtl/seek_step_with_heading_top.sv
// throughput: one transaction per cycle while out_ready is held high;
// 4 front stages, 34 square root cells, 2 product stages, 33 divide cells and the
// output register, all pipelined
// a stall holds only the filled stages, bubbles close up behind it
// reset (rst_n low, asynchronous) empties the pipeline and clears the configuration
// registers to 0; stage data registers are not reset
`default_nettype none

module seek_step_with_heading_top (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_wr_en,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [31:0]        cfg_data,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic signed [31:0] pos_x,
    input  wire logic signed [31:0] pos_y,
    input  wire logic signed [31:0] pos_z,
    input  wire logic [23:0]        time_step,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic signed [31:0]      new_x,
    output logic signed [31:0]      new_y,
    output logic signed [31:0]      new_z,
    output logic signed [15:0]      heading,
    output logic                    heading_valid,
    output logic                    end_reached
);
    import ssh_pkg::*;

    localparam int FRONT     = 4;
    localparam int ROOT_BASE = FRONT;
    localparam int M_BASE    = ROOT_BASE + SQ_BITS;
    localparam int DIV_BASE  = M_BASE + 2;
    localparam int OUT_IDX   = DIV_BASE + DIV_BITS;
    localparam int NST       = OUT_IDX + 1;

    // configuration registers
    logic [31:0] target_x_reg;
    logic [31:0] target_y_reg;
    logic [31:0] target_z_reg;
    logic [30:0] max_speed_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_x_reg  <= '0;
            target_y_reg  <= '0;
            target_z_reg  <= '0;
            max_speed_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_TARGET_X:  target_x_reg  <= cfg_data;
                CFG_TARGET_Y:  target_y_reg  <= cfg_data;
                CFG_TARGET_Z:  target_z_reg  <= cfg_data;
                CFG_MAX_SPEED: max_speed_reg <= cfg_data[30:0];
            endcase
        end
    end

    logic [2:0][31:0] tgt;
    assign tgt = {target_z_reg, target_y_reg, target_x_reg};

    // stage valids and load chain, a stage loads when empty or when it drains
    logic [NST-1:0] v;
    logic [NST:0]   load;

    always_comb
    begin
        load[NST] = out_ready;
        for (int k = NST - 1; k >= 0; k--)
        begin
            load[k] = !v[k] || load[k+1];
        end
    end

    assign in_ready = load[0];

    // front stages: differences, squares, sum
    logic [FRONT-1:0]   fv_reg;
    item_t              f_reg  [FRONT];
    item_t              f_next [FRONT];
    logic [2:0][31:0]   pin;
    logic signed [32:0] dd     [3];
    logic [54:0]        spd_prod;
    logic [16:0]        mh     [3];
    logic [15:0]        ml     [3];
    logic [65:0]        s_sum;

    assign pin = {pos_z, pos_y, pos_x};

    always_comb
    begin
        f_next[0] = '0;
        for (int a = 0; a < 3; a++)
        begin
            dd[a] = $signed({tgt[a][31], tgt[a]}) - $signed({pin[a][31], pin[a]});
            f_next[0].pos[a] = pin[a];
            f_next[0].neg[a] = dd[a][32];
            f_next[0].mag[a] = dd[a][32] ? 33'(-dd[a]) : 33'(dd[a]);
        end
        spd_prod = max_speed_reg * time_step;
        f_next[0].disp = (|spd_prod[54:49]) ? DISP_MAX : spd_prod[48:16];
        // rotation start, turned by pi when the z difference is negative
        f_next[0].cx = $signed({{3{dd[2][32]}}, dd[2], 24'b0});
        f_next[0].cy = $signed({{3{dd[0][32]}}, dd[0], 24'b0});
        f_next[0].cz = '0;
        if (dd[2][32])
        begin
            f_next[0].cx = -$signed({{3{dd[2][32]}}, dd[2], 24'b0});
            f_next[0].cy = -$signed({{3{dd[0][32]}}, dd[0], 24'b0});
            f_next[0].cz = dd[0][32] ? -PI_Q24 : PI_Q24;
        end

        // partial products of the squares
        f_next[1] = f_reg[0];
        for (int a = 0; a < 3; a++)
        begin
            mh[a] = f_reg[0].mag[a][32:16];
            ml[a] = f_reg[0].mag[a][15:0];
            f_next[1].pp_hh[a] = 34'(mh[a] * mh[a]);
            f_next[1].pp_hl[a] = 33'(mh[a] * ml[a]);
            f_next[1].pp_ll[a] = 32'(ml[a] * ml[a]);
        end

        // per axis square
        f_next[2] = f_reg[1];
        for (int a = 0; a < 3; a++)
        begin
            f_next[2].sqa[a] = 66'({f_reg[1].pp_hh[a], 32'b0})
                             + 66'({f_reg[1].pp_hl[a], 17'b0})
                             + 66'(f_reg[1].pp_ll[a]);
        end

        // squared length, heading threshold, root start
        f_next[3] = f_reg[2];
        s_sum = f_reg[2].sqa[0] + f_reg[2].sqa[1] + f_reg[2].sqa[2];
        f_next[3].sq   = {2'b00, s_sum};
        f_next[3].hval = s_sum >= HEAD_THRESH_SQ;
        f_next[3].rem  = '0;
        f_next[3].root = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fv_reg <= '0;
        end
        else
        begin
            if (load[0])
            begin
                fv_reg[0] <= in_valid;
            end
            for (int k = 1; k < FRONT; k++)
            begin
                if (load[k])
                begin
                    fv_reg[k] <= fv_reg[k-1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < FRONT; k++)
        begin
            if (load[k])
            begin
                f_reg[k] <= f_next[k];
            end
        end
    end

    // square root chain, also runs the heading rotation
    item_t          root_d [SQ_BITS+1];
    logic [SQ_BITS:0] root_v;

    assign root_d[0] = f_reg[FRONT-1];
    assign root_v[0] = fv_reg[FRONT-1];

    for (genvar i = 0; i < SQ_BITS; i++)
    begin : g_root
        ssh_root_cell #(
            .Idx(i)
        ) u_root (
            .clk   (clk),
            .rst_n (rst_n),
            .load  (load[ROOT_BASE+i]),
            .v_in  (root_v[i]),
            .d_in  (root_d[i]),
            .v_out (root_v[i+1]),
            .d_out (root_d[i+1])
        );
    end

    // snap decision and scaled step products
    logic [1:0] mv_reg;
    item_t      m_reg  [2];
    item_t      m_next [2];
    logic [65:0] numer [3];

    always_comb
    begin
        m_next[0] = root_d[SQ_BITS];
        m_next[0].reached = {1'b0, root_d[SQ_BITS].disp} >= root_d[SQ_BITS].root;
        for (int a = 0; a < 3; a++)
        begin
            m_next[0].ph[a] = 49'(root_d[SQ_BITS].mag[a] * root_d[SQ_BITS].disp[32:17]);
            m_next[0].pl[a] = 50'(root_d[SQ_BITS].mag[a] * root_d[SQ_BITS].disp[16:0]);
        end

        m_next[1] = m_reg[0];
        for (int a = 0; a < 3; a++)
        begin
            numer[a] = 66'({m_reg[0].ph[a], 17'b0}) + 66'(m_reg[0].pl[a]);
            m_next[1].drem[a] = {1'b0, numer[a][65:33]};
            m_next[1].dnum[a] = numer[a][32:0];
            m_next[1].quot[a] = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mv_reg <= '0;
        end
        else
        begin
            if (load[M_BASE])
            begin
                mv_reg[0] <= root_v[SQ_BITS];
            end
            if (load[M_BASE+1])
            begin
                mv_reg[1] <= mv_reg[0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load[M_BASE])
        begin
            m_reg[0] <= m_next[0];
        end
        if (load[M_BASE+1])
        begin
            m_reg[1] <= m_next[1];
        end
    end

    // divide chain
    item_t             div_d [DIV_BITS+1];
    logic [DIV_BITS:0] div_v;

    assign div_d[0] = m_reg[1];
    assign div_v[0] = mv_reg[1];

    for (genvar i = 0; i < DIV_BITS; i++)
    begin : g_div
        ssh_div_cell u_div (
            .clk   (clk),
            .rst_n (rst_n),
            .load  (load[DIV_BASE+i]),
            .v_in  (div_v[i]),
            .d_in  (div_d[i]),
            .v_out (div_v[i+1]),
            .d_out (div_d[i+1])
        );
    end

    // output register
    logic                ov_reg;
    logic [2:0][31:0]    newp_reg;
    logic [2:0][31:0]    newp_next;
    logic signed [15:0]  heading_reg;
    logic signed [15:0]  heading_next;
    logic                hval_reg;
    logic                reached_reg;
    logic signed [28:0]  hz;
    logic signed [28:0]  hs;
    item_t               last;

    assign last = div_d[DIV_BITS];

    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            if (last.reached)
            begin
                newp_next[a] = tgt[a];
            end
            else if (last.neg[a])
            begin
                newp_next[a] = last.pos[a] - last.quot[a][31:0];
            end
            else
            begin
                newp_next[a] = last.pos[a] + last.quot[a][31:0];
            end
        end
        hz = $signed({last.cz[27], last.cz}) + 29'sd1024;
        hs = hz >>> 11;
        priority if (!last.hval)
        begin
            heading_next = '0;
        end
        else if (hs > HEAD_LIMIT)
        begin
            heading_next = 16'(HEAD_LIMIT);
        end
        else if (hs < -HEAD_LIMIT)
        begin
            heading_next = 16'(-HEAD_LIMIT);
        end
        else
        begin
            heading_next = 16'(hs);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ov_reg <= 1'b0;
        end
        else if (load[OUT_IDX])
        begin
            ov_reg <= div_v[DIV_BITS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (load[OUT_IDX])
        begin
            newp_reg    <= newp_next;
            heading_reg <= heading_next;
            hval_reg    <= last.hval;
            reached_reg <= last.reached;
        end
    end

    // collect stage valids
    always_comb
    begin
        v[FRONT-1:0] = fv_reg;
        for (int i = 0; i < SQ_BITS; i++)
        begin
            v[ROOT_BASE+i] = root_v[i+1];
        end
        v[M_BASE]   = mv_reg[0];
        v[M_BASE+1] = mv_reg[1];
        for (int i = 0; i < DIV_BITS; i++)
        begin
            v[DIV_BASE+i] = div_v[i+1];
        end
        v[OUT_IDX] = ov_reg;
    end

    assign out_valid     = ov_reg;
    assign new_x         = newp_reg[0];
    assign new_y         = newp_reg[1];
    assign new_z         = newp_reg[2];
    assign heading       = heading_reg;
    assign heading_valid = hval_reg;
    assign end_reached   = reached_reg;

    // checks
    ap_snap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && end_reached |->
            new_x == target_x_reg && new_y == target_y_reg && new_z == target_z_reg)
        else $error("snapped result differs from target");

    ap_head_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !heading_valid |-> heading == 16'sd0)
        else $error("heading not zero without heading_valid");

    ap_head_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> heading <= 16'sd25736 && heading >= -16'sd25736)
        else $error("heading out of range");

    ap_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty output stage");

endmodule

`default_nettype wire
